@@ hw/rtl/rcslex_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rcslex_pkg;

    // Input actions.
    localparam logic [1:0] ACT_DATA   = 2'd0;
    localparam logic [1:0] ACT_EOF    = 2'd1;
    localparam logic [1:0] ACT_SET_KW = 2'd2;

    // Result types.
    localparam logic RES_CONTENT = 1'b0;
    localparam logic RES_TOKEN   = 1'b1;

    // Token kinds below the keyword range.
    localparam logic [4:0] KIND_EOF    = 5'd0;
    localparam logic [4:0] KIND_JUNK   = 5'd1;
    localparam logic [4:0] KIND_IDENT  = 5'd2;
    localparam logic [4:0] KIND_NUMBER = 5'd3;
    localparam logic [4:0] KIND_STRING = 5'd4;
    localparam logic [4:0] KIND_COLON  = 5'd5;
    localparam logic [4:0] KIND_SEMI   = 5'd6;

    localparam logic [7:0] CHAR_AT = 8'h40;

    // Keyword table. Spellings are right-aligned in 64 bits, first letter highest.
    localparam int NUM_KW = 17;

    localparam logic [63:0] KW_TEXT [NUM_KW] = '{
        64'("access"), 64'("author"), 64'("branch"), 64'("branches"),
        64'("comment"), 64'("date"), 64'("desc"), 64'("expand"),
        64'("head"), 64'("locks"), 64'("log"), 64'("next"),
        64'("state"), 64'("strict"), 64'("suffix"), 64'("symbols"),
        64'("text")
    };

    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd6, 4'd6, 4'd6, 4'd8, 4'd7, 4'd4, 4'd4, 4'd6, 4'd4,
        4'd5, 4'd3, 4'd4, 4'd5, 4'd6, 4'd6, 4'd7, 4'd4
    };

    localparam logic [4:0] KW_KIND [NUM_KW] = '{
        5'd7, 5'd8, 5'd9, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14,
        5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22
    };

    // Depth of the result queue.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef enum logic [2:0] {
        CL_JUNK,
        CL_SPACE,
        CL_AT,
        CL_DIGIT,
        CL_COLON,
        CL_SEMI,
        CL_WORD
    } byte_class_t;

    typedef struct packed {
        logic       result_type;
        logic [4:0] token_kind;
        logic [7:0] text_byte;
        logic       last;
    } result_t;

    // Up to two results produced by one input beat, in order.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } scan_out_t;

    // Latin-1 class of a byte.
    function automatic byte_class_t byte_class(input logic [7:0] c);
        byte_class_t cl;
        if (c < 8'd8)
            cl = CL_JUNK;
        else if (c < 8'd14)
            cl = CL_SPACE;
        else if (c < 8'd32)
            cl = CL_JUNK;
        else if (c == 8'd32)
            cl = CL_SPACE;
        else if (c == 8'h2E || (c >= 8'h30 && c <= 8'h39))
            cl = CL_DIGIT;
        else if (c == 8'h3A)
            cl = CL_COLON;
        else if (c == 8'h3B)
            cl = CL_SEMI;
        else if (c == CHAR_AT)
            cl = CL_AT;
        else if (c < 8'd127)
            cl = CL_WORD;
        else if (c < 8'd160)
            cl = CL_JUNK;
        else
            cl = CL_WORD;
        return cl;
    endfunction

    // Letter at position pos of keyword idx; only meaningful for pos below its length.
    function automatic logic [7:0] kw_char(input logic [4:0] idx, input logic [2:0] pos);
        logic [3:0]  sh;
        logic [63:0] word;
        sh   = KW_LEN[idx] - 4'd1 - {1'b0, pos};
        word = KW_TEXT[idx] >> {sh, 3'b000};
        return word[7:0];
    endfunction

    function automatic result_t mk_result(input logic rtype, input logic [4:0] kind,
                                          input logic [7:0] text);
        result_t r;
        r.result_type = rtype;
        r.token_kind  = kind;
        r.text_byte   = text;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rcslex_kw.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Keyword candidate tracking: all 17 spellings are compared in parallel.
module rcslex_kw (
    input  wire logic [rcslex_pkg::NUM_KW-1:0] match_cur,
    input  wire logic [3:0]                    len_cur,
    input  wire logic                          restart,
    input  wire logic [7:0]                    byte_in,
    output logic      [rcslex_pkg::NUM_KW-1:0] match_next,
    output logic      [3:0]                    len_next,
    output logic                               hit,
    output logic      [4:0]                    hit_kind
);

    logic [rcslex_pkg::NUM_KW-1:0] base_match;
    logic [3:0]                    base_len;

    // A fresh identifier starts from all candidates at length zero.
    always_comb
    begin
        base_match = restart ? '1 : match_cur;
        base_len   = restart ? 4'd0 : len_cur;
        for (int i = 0; i < rcslex_pkg::NUM_KW; i++)
        begin
            match_next[i] = base_match[i]
                && (base_len < rcslex_pkg::KW_LEN[i])
                && (rcslex_pkg::kw_char(5'(i), base_len[2:0]) == byte_in);
        end
        len_next = (base_len == 4'd15) ? 4'd15 : base_len + 4'd1;
    end

    // A surviving candidate of exactly the current length is a keyword; first one wins.
    always_comb
    begin
        hit      = 1'b0;
        hit_kind = rcslex_pkg::KIND_IDENT;
        for (int i = rcslex_pkg::NUM_KW - 1; i >= 0; i--)
        begin
            if (match_cur[i] && rcslex_pkg::KW_LEN[i] == len_cur)
            begin
                hit      = 1'b1;
                hit_kind = rcslex_pkg::KW_KIND[i];
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/rcslex_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Scanner: lexer state and the results of one input beat.
module rcslex_scan (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  advance,
    input  wire logic [1:0]            action,
    input  wire logic [7:0]            byte_value,
    output rcslex_pkg::scan_out_t      scan_out
);

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_IDENT  = 3'd1,
        MODE_NUMBER = 3'd2,
        MODE_STRING = 3'd3,
        MODE_STR_AT = 3'd4
    } mode_t;

    mode_t                         mode_reg, mode_next;
    logic                          expect_reg, expect_next;
    logic [rcslex_pkg::NUM_KW-1:0] match_reg;
    logic [3:0]                    len_reg;

    rcslex_pkg::byte_class_t       cls;
    logic                          is_word;
    logic                          continue_ident;
    logic                          do_start;
    logic                          track_en;
    logic [rcslex_pkg::NUM_KW-1:0] kw_match_next;
    logic [3:0]                    kw_len_next;
    logic                          kw_hit;
    logic [4:0]                    kw_hit_kind;
    logic [4:0]                    ident_kind;
    logic                          a_valid, b_valid;
    rcslex_pkg::result_t           a_res, b_res;

    assign cls            = rcslex_pkg::byte_class(byte_value);
    assign is_word        = (cls == rcslex_pkg::CL_WORD);
    assign continue_ident = (action == rcslex_pkg::ACT_DATA) && (mode_reg == MODE_IDENT)
                            && (is_word || cls == rcslex_pkg::CL_DIGIT);
    assign ident_kind     = (expect_reg && kw_hit) ? kw_hit_kind : rcslex_pkg::KIND_IDENT;

    rcslex_kw u_kw (
        .match_cur  (match_reg),
        .len_cur    (len_reg),
        .restart    (!continue_ident),
        .byte_in    (byte_value),
        .match_next (kw_match_next),
        .len_next   (kw_len_next),
        .hit        (kw_hit),
        .hit_kind   (kw_hit_kind)
    );

    // Results: a closes the open token or carries content, b comes from a fresh start or eof.
    always_comb
    begin
        mode_next   = mode_reg;
        expect_next = expect_reg;
        a_valid     = 1'b0;
        b_valid     = 1'b0;
        a_res       = '0;
        b_res       = '0;
        do_start    = 1'b0;

        case (action)
            rcslex_pkg::ACT_DATA:
            begin
                case (mode_reg)
                    MODE_IDENT:
                    begin
                        a_valid = 1'b1;
                        if (continue_ident)
                        begin
                            a_res = rcslex_pkg::mk_result(rcslex_pkg::RES_CONTENT,
                                                          rcslex_pkg::KIND_IDENT, byte_value);
                        end
                        else
                        begin
                            a_res = rcslex_pkg::mk_result(rcslex_pkg::RES_TOKEN, ident_kind,
                                                          8'd0);
                            if (expect_reg && kw_hit)
                                expect_next = 1'b0;
                            do_start = 1'b1;
                        end
                    end
                    MODE_NUMBER:
                    begin
                        a_valid = 1'b1;
                        if (cls == rcslex_pkg::CL_DIGIT)
                        begin
                            a_res = rcslex_pkg::mk_result(rcslex_pkg::RES_CONTENT,
                                                          rcslex_pkg::KIND_NUMBER, byte_value);
                        end
                        else
                        begin
                            a_res = rcslex_pkg::mk_result(rcslex_pkg::RES_TOKEN,
                                                          rcslex_pkg::KIND_NUMBER, 8'd0);
                            do_start = 1'b1;
                        end
                    end
                    MODE_STRING:
                    begin
                        if (cls == rcslex_pkg::CL_AT)
                        begin
                            mode_next = MODE_STR_AT;
                        end
                        else
                        begin
                            a_valid = 1'b1;
                            a_res   = rcslex_pkg::mk_result(rcslex_pkg::RES_CONTENT,
                                                            rcslex_pkg::KIND_STRING, byte_value);
                        end
                    end
                    MODE_STR_AT:
                    begin
                        a_valid = 1'b1;
                        if (cls == rcslex_pkg::CL_AT)
                        begin
                            a_res     = rcslex_pkg::mk_result(rcslex_pkg::RES_CONTENT,
                                                              rcslex_pkg::KIND_STRING,
                                                              rcslex_pkg::CHAR_AT);
                            mode_next = MODE_STRING;
                        end
                        else
                        begin
                            a_res    = rcslex_pkg::mk_result(rcslex_pkg::RES_TOKEN,
                                                             rcslex_pkg::KIND_STRING, 8'd0);
                            do_start = 1'b1;
                        end
                    end
                    default:
                    begin
                        do_start = 1'b1;
                    end
                endcase

                // The byte that ended a token, or any byte while idle, opens what comes next.
                if (do_start)
                begin
                    mode_next = MODE_IDLE;
                    case (cls)
                        rcslex_pkg::CL_JUNK:
                        begin
                            b_valid = 1'b1;
                            b_res   = rcslex_pkg::mk_result(rcslex_pkg::RES_TOKEN,
                                                            rcslex_pkg::KIND_JUNK, 8'd0);
                        end
                        rcslex_pkg::CL_SPACE:
                        begin
                            b_valid = 1'b0;
                        end
                        rcslex_pkg::CL_AT:
                        begin
                            mode_next = MODE_STRING;
                        end
                        rcslex_pkg::CL_DIGIT:
                        begin
                            mode_next = MODE_NUMBER;
                            b_valid   = 1'b1;
                            b_res     = rcslex_pkg::mk_result(rcslex_pkg::RES_CONTENT,
                                                              rcslex_pkg::KIND_NUMBER, byte_value);
                        end
                        rcslex_pkg::CL_COLON:
                        begin
                            b_valid = 1'b1;
                            b_res   = rcslex_pkg::mk_result(rcslex_pkg::RES_TOKEN,
                                                            rcslex_pkg::KIND_COLON, 8'd0);
                        end
                        rcslex_pkg::CL_SEMI:
                        begin
                            expect_next = 1'b1;
                            b_valid     = 1'b1;
                            b_res       = rcslex_pkg::mk_result(rcslex_pkg::RES_TOKEN,
                                                                rcslex_pkg::KIND_SEMI, 8'd0);
                        end
                        default:
                        begin
                            mode_next = MODE_IDENT;
                            b_valid   = 1'b1;
                            b_res     = rcslex_pkg::mk_result(rcslex_pkg::RES_CONTENT,
                                                              rcslex_pkg::KIND_IDENT, byte_value);
                        end
                    endcase
                end
            end
            rcslex_pkg::ACT_EOF:
            begin
                case (mode_reg)
                    MODE_IDENT:
                    begin
                        a_valid = 1'b1;
                        a_res   = rcslex_pkg::mk_result(rcslex_pkg::RES_TOKEN, ident_kind, 8'd0);
                        if (expect_reg && kw_hit)
                            expect_next = 1'b0;
                    end
                    MODE_NUMBER:
                    begin
                        a_valid = 1'b1;
                        a_res   = rcslex_pkg::mk_result(rcslex_pkg::RES_TOKEN,
                                                        rcslex_pkg::KIND_NUMBER, 8'd0);
                    end
                    MODE_STRING, MODE_STR_AT:
                    begin
                        a_valid = 1'b1;
                        a_res   = rcslex_pkg::mk_result(rcslex_pkg::RES_TOKEN,
                                                        rcslex_pkg::KIND_STRING, 8'd0);
                    end
                    default:
                    begin
                        a_valid = 1'b0;
                    end
                endcase
                mode_next = MODE_IDLE;
                b_valid   = 1'b1;
                b_res     = rcslex_pkg::mk_result(rcslex_pkg::RES_TOKEN,
                                                  rcslex_pkg::KIND_EOF, 8'd0);
            end
            rcslex_pkg::ACT_SET_KW:
            begin
                expect_next = 1'b1;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    // Pack the results in order and flag the final one.
    always_comb
    begin
        scan_out = '0;
        if (a_valid && b_valid)
        begin
            scan_out.count       = 2'd2;
            scan_out.first       = a_res;
            scan_out.second      = b_res;
            scan_out.second.last = 1'b1;
        end
        else if (a_valid || b_valid)
        begin
            scan_out.count      = 2'd1;
            scan_out.first      = a_valid ? a_res : b_res;
            scan_out.first.last = 1'b1;
        end
    end

    // Keyword tracking moves only on identifier bytes.
    assign track_en = (action == rcslex_pkg::ACT_DATA) && (continue_ident || (do_start && is_word));

    // Lexer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            expect_reg <= 1'b1;
            match_reg  <= '1;
            len_reg    <= 4'd0;
        end
        else if (advance)
        begin
            mode_reg   <= mode_next;
            expect_reg <= expect_next;
            if (track_en)
            begin
                match_reg <= kw_match_next;
                len_reg   <= kw_len_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/rcslex_out_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Result queue: takes up to two results per cycle, hands out one per beat.
module rcslex_out_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire rcslex_pkg::scan_out_t scan_out,
    output logic                      room2,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output rcslex_pkg::result_t       head
);

    localparam int PW = rcslex_pkg::OUT_PTR_W;
    localparam int CW = rcslex_pkg::OUT_CNT_W;

    rcslex_pkg::result_t mem [rcslex_pkg::OUT_DEPTH];
    logic [PW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]       rd_ptr_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       n_push;
    logic                pop;
    logic [CW:0]         free_slots;

    assign pop        = out_valid && !out_stall;
    assign out_valid  = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign n_push     = push ? CW'(scan_out.count) : '0;
    assign free_slots = (CW+1)'(rcslex_pkg::OUT_DEPTH) - {1'b0, count_reg} + (CW+1)'(pop);
    assign room2      = (free_slots >= (CW+1)'(2));
    assign wr_ptr_next = wr_ptr_reg + PW'(1);

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push && scan_out.count != 2'd0)
            mem[wr_ptr_reg] <= scan_out.first;
        if (push && scan_out.count == 2'd2)
            mem[wr_ptr_next] <= scan_out.second;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PW'(n_push);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            count_reg <= count_reg + n_push - CW'(pop);
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/rcs_token_lexer_unit.sv @@
// RCS file tokenizer, one byte per input beat.
// Input channel: in_valid / in_stall with action (0 data byte, 1 end of input,
// 2 expect a keyword) and byte_value. A beat is taken when in_valid is high and
// in_stall is low.
// Output channel: out_valid / out_stall with result_type, token_kind, text_byte
// and last. Each input beat gives zero, one or two result beats; last marks the
// final result of an input beat.
// An accepted beat is scanned from the input register, and its results are
// written into the result queue, from whose head they are offered.
// Throughput: one input beat per cycle while each beat gives at most one result
// and the receiver does not stall; a beat that both closes a token and starts
// another gives two results. The input register holds a beat until the
// four-entry result queue has room for two results, which is what sets in_stall.
// When the receiver stalls, the queued results hold and in_stall rises once the
// queue has room for fewer than two results. Reset empties the queue and input
// register, returns the scanner to idle with a keyword expected.
`timescale 1ns / 1ps
`default_nettype none

module rcs_token_lexer_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] action,
    input  wire logic [7:0] byte_value,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            result_type,
    output logic [4:0]      token_kind,
    output logic [7:0]      text_byte,
    output logic            last
);

    logic                  in_valid_reg;
    logic [1:0]            action_reg;
    logic [7:0]            byte_reg;
    logic                  load;
    logic                  advance;
    logic                  room2;
    rcslex_pkg::scan_out_t scan_out;
    rcslex_pkg::result_t   head;

    assign advance  = in_valid_reg && room2;
    assign in_stall = in_valid_reg && !room2;
    assign load     = in_valid && !in_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (load)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            action_reg <= action;
            byte_reg   <= byte_value;
        end
    end

    rcslex_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .action     (action_reg),
        .byte_value (byte_reg),
        .scan_out   (scan_out)
    );

    rcslex_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance),
        .scan_out  (scan_out),
        .room2     (room2),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign result_type = head.result_type;
    assign token_kind  = head.token_kind;
    assign text_byte   = head.text_byte;
    assign last        = head.last;

endmodule

`default_nettype wire

@@ tb/sv/rcs_token_lexer_check.sv @@
`timescale 1ns / 1ps

module rcs_token_lexer_check
    import rcslex_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic [1:0] action,
    input  wire logic [7:0] byte_value,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic       result_type,
    input  wire logic [4:0] token_kind,
    input  wire logic [7:0] text_byte,
    input  wire logic       last,
    output int              fail_total,
    output int              pending_count,
    output int              tokens_closed
);

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_WORD,
        SCAN_NUMBER,
        SCAN_STRING,
        SCAN_STRING_AT
    } scan_t;

    // Lexer state as predicted from the accepted input beats.
    scan_t             scan_mode;
    bit                expect_kw;
    logic [NUM_KW-1:0] kw_cand;
    logic [3:0]        word_len;

    // Result beats predicted but not yet seen on the output channel.
    result_t queued_lex_beats[$];

    int mismatches;
    int closed_seen;
    int beats_checked;

    // Sort a byte into its Latin-1 class.
    function automatic byte_class_t classify(input logic [7:0] c);
        if (c < 8'd8)
            return CL_JUNK;
        if (c < 8'd14)
            return CL_SPACE;
        if (c < 8'd32)
            return CL_JUNK;
        if (c == 8'd32)
            return CL_SPACE;
        if (c == 8'h2E || (c >= 8'h30 && c <= 8'h39))
            return CL_DIGIT;
        if (c == 8'h3A)
            return CL_COLON;
        if (c == 8'h3B)
            return CL_SEMI;
        if (c == CHAR_AT)
            return CL_AT;
        if (c < 8'd127)
            return CL_WORD;
        if (c < 8'd160)
            return CL_JUNK;
        return CL_WORD;
    endfunction

    // Letter at position pos of keyword idx, counted from the first letter.
    function automatic logic [7:0] kw_letter(input int idx, input int pos);
        logic [63:0] spelled;
        spelled = KW_TEXT[idx] >> (8 * (int'(KW_LEN[idx]) - 1 - pos));
        return spelled[7:0];
    endfunction

    function automatic void push_result(input logic rtype, input logic [4:0] kind,
                                        input logic [7:0] data);
        result_t r;
        r.result_type = rtype;
        r.token_kind  = kind;
        r.text_byte   = data;
        r.last        = 1'b0;
        queued_lex_beats = {queued_lex_beats, r};
    endfunction

    // Drop every keyword candidate that the new letter rules out.
    function automatic void match_letter(input logic [7:0] c);
        for (int i = 0; i < NUM_KW; i++)
            if (kw_cand[i] && (word_len >= KW_LEN[i] || kw_letter(i, word_len) != c))
                kw_cand[i] = 1'b0;
        if (word_len != 4'd15)
            word_len = word_len + 4'd1;
    endfunction

    // Close an identifier, as a keyword when one is expected and spelled out.
    function automatic void close_word();
        logic [4:0] kind;
        bit         found;
        kind  = KIND_IDENT;
        found = 1'b0;
        if (expect_kw)
            for (int i = 0; i < NUM_KW; i++)
                if (!found && kw_cand[i] && KW_LEN[i] == word_len) begin
                    kind  = KW_KIND[i];
                    found = 1'b1;
                end
        if (found)
            expect_kw = 1'b0;
        push_result(RES_TOKEN, kind, 8'h00);
        scan_mode = SCAN_IDLE;
    endfunction

    // Handle a byte seen between tokens.
    function automatic void open_token(input logic [7:0] c);
        case (classify(c))
            CL_JUNK:  push_result(RES_TOKEN, KIND_JUNK, 8'h00);
            CL_SPACE: ;
            CL_AT:    scan_mode = SCAN_STRING;
            CL_DIGIT:
            begin
                scan_mode = SCAN_NUMBER;
                push_result(RES_CONTENT, KIND_NUMBER, c);
            end
            CL_COLON: push_result(RES_TOKEN, KIND_COLON, 8'h00);
            CL_SEMI:
            begin
                expect_kw = 1'b1;
                push_result(RES_TOKEN, KIND_SEMI, 8'h00);
            end
            default:
            begin
                scan_mode = SCAN_WORD;
                word_len  = 4'd0;
                kw_cand   = '1;
                match_letter(c);
                push_result(RES_CONTENT, KIND_IDENT, c);
            end
        endcase
    endfunction

    // Predict the result beats of one accepted input beat.
    function automatic void scan_beat(input logic [1:0] a, input logic [7:0] c);
        int          depth_in;
        byte_class_t cl;
        depth_in = queued_lex_beats.size();
        cl       = classify(c);
        if (a == ACT_DATA) begin
            case (scan_mode)
                SCAN_WORD:
                    if (cl == CL_WORD || cl == CL_DIGIT) begin
                        match_letter(c);
                        push_result(RES_CONTENT, KIND_IDENT, c);
                    end else begin
                        close_word();
                        open_token(c);
                    end
                SCAN_NUMBER:
                    if (cl == CL_DIGIT) begin
                        push_result(RES_CONTENT, KIND_NUMBER, c);
                    end else begin
                        push_result(RES_TOKEN, KIND_NUMBER, 8'h00);
                        scan_mode = SCAN_IDLE;
                        open_token(c);
                    end
                SCAN_STRING:
                    if (cl == CL_AT)
                        scan_mode = SCAN_STRING_AT;
                    else
                        push_result(RES_CONTENT, KIND_STRING, c);
                SCAN_STRING_AT:
                    if (cl == CL_AT) begin
                        push_result(RES_CONTENT, KIND_STRING, CHAR_AT);
                        scan_mode = SCAN_STRING;
                    end else begin
                        push_result(RES_TOKEN, KIND_STRING, 8'h00);
                        scan_mode = SCAN_IDLE;
                        open_token(c);
                    end
                default:
                begin
                    scan_mode = SCAN_IDLE;
                    open_token(c);
                end
            endcase
        end else if (a == ACT_EOF) begin
            // An open token closes before the end mark.
            case (scan_mode)
                SCAN_WORD:      close_word();
                SCAN_NUMBER:    push_result(RES_TOKEN, KIND_NUMBER, 8'h00);
                SCAN_STRING,
                SCAN_STRING_AT: push_result(RES_TOKEN, KIND_STRING, 8'h00);
                default:        ;
            endcase
            scan_mode = SCAN_IDLE;
            push_result(RES_TOKEN, KIND_EOF, 8'h00);
        end else if (a == ACT_SET_KW) begin
            expect_kw = 1'b1;
        end
        // Mark the final result beat of this input beat.
        if (queued_lex_beats.size() > depth_in)
            queued_lex_beats[queued_lex_beats.size() - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("[%0t] result beat %0d: %s expected %0d, got %0d",
                 $realtime, beats_checked, what, want, got);
        mismatches++;
    endtask

    // Compare each output beat with the oldest prediction, then predict the new input beat.
    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            scan_mode     = SCAN_IDLE;
            expect_kw     = 1'b1;
            kw_cand       = '1;
            word_len      = 4'd0;
            queued_lex_beats.delete();
            mismatches    = 0;
            closed_seen   = 0;
            beats_checked = 0;
            fail_total    <= 0;
            pending_count <= 0;
            tokens_closed <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (queued_lex_beats.size() == 0) begin
                    report_mismatch("beat with none pending, token_kind", -1, token_kind);
                end else begin
                    want = queued_lex_beats.pop_front();
                    if (result_type != want.result_type)
                        report_mismatch("result_type", want.result_type, result_type);
                    if (token_kind != want.token_kind)
                        report_mismatch("token_kind", want.token_kind, token_kind);
                    if (text_byte != want.text_byte)
                        report_mismatch("text_byte", want.text_byte, text_byte);
                    if (last != want.last)
                        report_mismatch("last", want.last, last);
                end
                if (result_type == RES_TOKEN)
                    closed_seen++;
                beats_checked++;
            end
            if (in_valid && !in_stall)
                scan_beat(action, byte_value);
            fail_total    <= mismatches;
            pending_count <= queued_lex_beats.size();
            tokens_closed <= closed_seen;
        end
    end

endmodule

@@ tb/sv/rcs_token_lexer_unit_tb.sv @@
`timescale 1ns / 1ps

module rcs_token_lexer_unit_tb;
    import rcslex_pkg::*;

    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int         RANDOM_BEATS = 950;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         IDLE_LIMIT   = 4000;

    logic       clk;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic [1:0] action     = ACT_DATA;
    logic [7:0] byte_value = 8'h00;
    logic       out_stall  = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic       result_type;
    logic [4:0] token_kind;
    logic [7:0] text_byte;
    logic       last;

    int fail_total;
    int pending_count;
    int tokens_closed;

    // Stimulus controls shared by the sender and the receiver.
    bit hold_go   = 1'b0;
    bit tx_quiet  = 1'b0;
    bit rx_quiet  = 1'b0;
    int beats_sent = 0;

    string kw_words [17] = '{
        "access", "author", "branch", "branches", "comment", "date", "desc",
        "expand", "head", "locks", "log", "next", "state", "strict", "suffix",
        "symbols", "text"
    };

    rcs_token_lexer_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .byte_value  (byte_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_type (result_type),
        .token_kind  (token_kind),
        .text_byte   (text_byte),
        .last        (last)
    );

    rcs_token_lexer_check u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .byte_value    (byte_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_type   (result_type),
        .token_kind    (token_kind),
        .text_byte     (text_byte),
        .last          (last),
        .fail_total    (fail_total),
        .pending_count (pending_count),
        .tokens_closed (tokens_closed)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Sender idle gap: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_quiet || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one input beat and hold it until it is taken.
    task automatic send_beat(input logic [1:0] a, input logic [7:0] c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= a;
        byte_value <= c;
        do @(posedge clk); while (in_stall);
        if (a != ACT_UNUSED)
            beats_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(ACT_DATA, s[i]);
    endtask

    // Stop offering beats until every predicted result beat has come out.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
    endtask

    // A byte that continues an identifier; digits only after the first letter.
    function automatic logic [7:0] word_char(input bit allow_digit);
        string punct;
        int    r;
        punct = "!\"#$%&'()*+,-/<=>?[]^_`{|}~";
        r     = $urandom_range(0, 99);
        if (allow_digit && r < 15)
            return ($urandom_range(0, 10) == 10) ? 8'h2E : 8'h30 + 8'($urandom_range(0, 9));
        if (r < 70)
            return 8'h61 + 8'($urandom_range(0, 25));
        if (r < 82)
            return 8'h41 + 8'($urandom_range(0, 25));
        if (r < 90)
            return 8'($urandom_range(160, 255));
        return punct[$urandom_range(0, punct.len() - 1)];
    endfunction

    task automatic send_sep();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            send_beat(ACT_DATA, 8'h20);
        else if (r < 9)
            send_beat(ACT_DATA, 8'($urandom_range(8, 13)));
        else
            send_beat(ACT_DATA, 8'h3A);
    endtask

    task automatic send_number();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
            send_beat(ACT_DATA, ($urandom_range(0, 4) == 0) ? 8'h2E
                                                           : 8'h30 + 8'($urandom_range(0, 9)));
    endtask

    // Identifier of random length, now and then long enough to saturate the length count.
    task automatic send_word();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        send_beat(ACT_DATA, word_char(1'b0));
        for (int i = 1; i < n; i++) begin
            if ($urandom_range(0, 19) == 0)
                send_beat(ACT_SET_KW, 8'($urandom));
            send_beat(ACT_DATA, word_char(1'b1));
        end
    endtask

    // String with doubled at signs; a few stay open and swallow what follows.
    task automatic send_string();
        int         n;
        logic [7:0] c;
        n = $urandom_range(0, 12);
        send_beat(ACT_DATA, CHAR_AT);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_beat(ACT_DATA, CHAR_AT);
                send_beat(ACT_DATA, CHAR_AT);
            end else begin
                c = 8'($urandom);
                send_beat(ACT_DATA, (c == CHAR_AT) ? 8'h0A : c);
            end
        end
        if ($urandom_range(0, 9) != 0)
            send_beat(ACT_DATA, CHAR_AT);
    endtask

    // One stretch of random input: mostly RCS-style phrases, the rest loose tokens and noise.
    task automatic send_random_phrase();
        int    r;
        string s;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            send_text(kw_words[$urandom_range(0, 16)]);
            send_sep();
            case ($urandom_range(0, 3))
                0:       send_number();
                1:       send_word();
                2:       send_string();
                default: ;
            endcase
            if ($urandom_range(0, 3) == 0) begin
                send_beat(ACT_DATA, 8'h3A);
                send_number();
            end
            send_beat(ACT_DATA, 8'h3B);
            send_sep();
        end else if (r < 55) begin
            // Near misses: a keyword one letter short or one letter long.
            s = kw_words[$urandom_range(0, 16)];
            if ($urandom_range(0, 1) == 0) begin
                send_text(s.substr(0, s.len() - 2));
            end else begin
                send_text(s);
                send_beat(ACT_DATA, word_char(1'b1));
            end
            send_sep();
        end else if (r < 63) begin
            send_word();
        end else if (r < 69) begin
            send_number();
        end else if (r < 75) begin
            send_string();
        end else if (r < 85) begin
            send_beat(ACT_DATA, 8'($urandom));
        end else if (r < 90) begin
            send_beat(ACT_SET_KW, 8'($urandom));
        end else if (r < 95) begin
            send_sep();
        end else if (r < 98) begin
            send_beat(ACT_EOF, 8'($urandom));
        end else begin
            send_beat(ACT_UNUSED, 8'($urandom));
        end
    endtask

    // Receiver: random stalls, one long hold-off, and quiet stretches.
    initial
    begin : receiver
        int stall_left;
        bit held;
        stall_left = 0;
        held       = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_go && !held) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                stall_left = 0;
            end else if (rx_quiet) begin
                out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else if ($urandom_range(0, 99) < 25) begin
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(1, 3);
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // End the run when neither channel moves a beat for too long.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin : stimulus
        bit drained;
        int stop_at;
        drained = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Keyword closed by a colon, which gives two results from one byte.
        send_text("head:");
        // Keyword request inside an identifier applies when it closes.
        send_text("lo");
        send_beat(ACT_SET_KW, 8'h00);
        send_text("g ");
        // Number closed by a semicolon.
        send_text("1.2;");
        // String with a doubled at sign, closed by a junk byte of zero.
        send_text("@a@@@");
        send_beat(ACT_DATA, 8'h00);
        // Identifier of byte 0xFF left open at end of input.
        send_beat(ACT_DATA, 8'hFF);
        send_beat(ACT_EOF, 8'hFF);
        // Unterminated string at end of input.
        send_text("@z");
        send_beat(ACT_EOF, 8'h00);
        // The unused action changes nothing.
        send_beat(ACT_UNUSED, 8'hAA);
        wait_for_drain();

        stop_at = beats_sent + RANDOM_BEATS;
        while (beats_sent < stop_at) begin
            if (beats_sent >= 300)
                hold_go <= 1'b1;
            if (!drained && beats_sent >= 550) begin
                drained = 1'b1;
                wait_for_drain();
            end
            tx_quiet <= (beats_sent >= 650 && beats_sent < 760);
            rx_quiet <= (beats_sent >= 650 && beats_sent < 760);
            send_random_phrase();
        end

        // Let any stray result beat show up before the verdict.
        rx_quiet <= 1'b1;
        wait_for_drain();
        repeat (10) @(posedge clk);
        $display("Sent %0d input beats: directed cases, RCS-style phrases, strings, noise,",
                 beats_sent);
        $display("keyword requests and end marks; %0d tokens closed, with hold-off and drain.",
                 tokens_closed);
        if (fail_total == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
